[src/sevseg_pkg.sv]
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Segment patterns, register indexes and output constants shared by the
// display driver.
// ----------------------------------------------------------------------------
package sevseg_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DWELL_TICKS = 2'd0,
        REG_BLINK_TICKS = 2'd1,
        REG_DP_SLOT     = 2'd2
    } reg_index_t;

    localparam int unsigned REG_WIDTH   = 10;
    localparam int unsigned VALUE_WIDTH = 14;
    localparam int unsigned SEG_WIDTH   = 8;
    localparam int unsigned EN_WIDTH    = 4;

    localparam logic [REG_WIDTH-1:0] DWELL_RESET = 10'd3;
    localparam logic [REG_WIDTH-1:0] BLINK_RESET = 10'd700;
    localparam logic [1:0]           DP_RESET    = 2'd1;

    localparam logic [SEG_WIDTH-1:0] DP_BIT      = 8'h80;
    localparam logic [EN_WIDTH-1:0]  EN_ALL_OFF  = 4'hF;

    // Segment pattern for one decimal digit, segment A in bit 0.
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'b0111111;
            4'd1:    pat = 7'b0000110;
            4'd2:    pat = 7'b1011011;
            4'd3:    pat = 7'b1001111;
            4'd4:    pat = 7'b1100110;
            4'd5:    pat = 7'b1101101;
            4'd6:    pat = 7'b1111101;
            4'd7:    pat = 7'b0000111;
            4'd8:    pat = 7'b1111111;
            4'd9:    pat = 7'b1101111;
            default: pat = 7'b0000000;
        endcase
        return pat;
    endfunction

endpackage

[src/seven_segment_mux_display.sv]
// Pipeline: an accepted item passes the input stage register, then the output
// register. Throughput: one item per cycle unless m_tready stalls the output;
// the scan and blink counters advance once per accepted item and the digit
// split is constant-multiplier logic.
// Reset (rst_n, asynchronous, active low) empties the pipeline, loads the
// register defaults and restarts the scan at the leftmost digit in number mode.
// ----------------------------------------------------------------------------
// Multiplexed seven-segment display driver
// Scans DIGIT_COUNT decimal digits one at a time, or blinks all digits as "0",
// producing one segment/enable item per tick item.
// ----------------------------------------------------------------------------
module seven_segment_mux_display #(
    parameter int unsigned DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] show_value, [15:14] zero
    input  logic        s_tuser,   // [0] blink_mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] segments, [11:8] digit_enable_n,
                                   // [15:12] zero
);

    localparam int unsigned SLOT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGIT_COUNT - 1);
    localparam logic [2:0] LAST_POS = 3'(DIGIT_COUNT - 1);
    localparam logic [13:0] CLAMP_LIMIT = (DIGIT_COUNT == 2) ? 14'd99 :
                                          (DIGIT_COUNT == 3) ? 14'd999 : 14'd9999;

    // Configuration registers.
    logic [9:0] dwell_ticks_reg;
    logic [9:0] blink_ticks_reg;
    logic [1:0] dp_slot_reg;

    // Scan state.
    logic [SLOT_W-1:0] scan_slot_reg,   scan_slot_next;
    logic [9:0]        dwell_count_reg, dwell_count_next;
    logic              blink_phase_on_reg, blink_phase_on_next;
    logic [9:0]        blink_count_reg, blink_count_next;
    logic              last_mode_reg,   last_mode_next;

    // Input stage.
    logic              s1_valid_reg, s1_valid_next;
    logic [13:0]       s1_value_reg;
    logic              s1_blink_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_phase_reg;

    // Output stage.
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        seg_reg, seg_next;
    logic [3:0]        en_reg,  en_next;

    logic              accept;
    logic              out_ready;
    logic              mode_change;
    logic [SLOT_W-1:0] cur_slot;
    logic [9:0]        cur_dwell;
    logic              cur_phase;
    logic [9:0]        cur_blink;
    logic [9:0]        dwell_period;
    logic [9:0]        blink_period;

    // Digit split signals.
    logic [13:0] value_clamped;
    logic [29:0] prod_div10;
    logic [29:0] prod_div100;
    logic [27:0] prod_div1000;
    logic [9:0]  q1;
    logic [6:0]  q2;
    logic [3:0]  q3;
    logic [3:0]  digits [4];
    logic [2:0]  slot3;
    logic [2:0]  digit_pos;
    logic [3:0]  digit_sel;

    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, en_reg, seg_reg};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg <= sevseg_pkg::DWELL_RESET;
            blink_ticks_reg <= sevseg_pkg::BLINK_RESET;
            dp_slot_reg     <= sevseg_pkg::DP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                sevseg_pkg::REG_DWELL_TICKS: dwell_ticks_reg <= cfg_data;
                sevseg_pkg::REG_BLINK_TICKS: blink_ticks_reg <= cfg_data;
                sevseg_pkg::REG_DP_SLOT:     dp_slot_reg     <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Counter update for the accepted tick. A mode change restarts everything
    // before the item's slot and phase are taken.
    always_comb
    begin
        mode_change  = (s_tuser != last_mode_reg);
        cur_slot     = mode_change ? '0    : scan_slot_reg;
        cur_dwell    = mode_change ? 10'd0 : dwell_count_reg;
        cur_phase    = mode_change ? 1'b1  : blink_phase_on_reg;
        cur_blink    = mode_change ? 10'd0 : blink_count_reg;
        dwell_period = (dwell_ticks_reg == 10'd0) ? 10'd1 : dwell_ticks_reg;
        blink_period = (blink_ticks_reg == 10'd0) ? 10'd1 : blink_ticks_reg;

        scan_slot_next      = cur_slot;
        dwell_count_next    = cur_dwell;
        blink_phase_on_next = cur_phase;
        blink_count_next    = cur_blink;
        last_mode_next      = s_tuser;

        if (s_tuser)
        begin
            if ((11'(cur_blink) + 11'd1) >= 11'(blink_period))
            begin
                blink_count_next    = 10'd0;
                blink_phase_on_next = !cur_phase;
            end
            else
            begin
                blink_count_next = cur_blink + 10'd1;
            end
        end
        else
        begin
            if ((11'(cur_dwell) + 11'd1) >= 11'(dwell_period))
            begin
                dwell_count_next = 10'd0;
                scan_slot_next   = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
            end
            else
            begin
                dwell_count_next = cur_dwell + 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_slot_reg      <= '0;
            dwell_count_reg    <= 10'd0;
            blink_phase_on_reg <= 1'b1;
            blink_count_reg    <= 10'd0;
            last_mode_reg      <= 1'b0;
        end
        else if (accept)
        begin
            scan_slot_reg      <= scan_slot_next;
            dwell_count_reg    <= dwell_count_next;
            blink_phase_on_reg <= blink_phase_on_next;
            blink_count_reg    <= blink_count_next;
            last_mode_reg      <= last_mode_next;
        end
    end

    // Input stage register.
    assign s1_valid_next = accept || (s1_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= s_tdata[13:0];
            s1_blink_reg <= s_tuser;
            s1_slot_reg  <= cur_slot;
            s1_phase_reg <= cur_phase;
        end
    end

    // Decimal split by reciprocal multiplication; exact for values up to 9999.
    always_comb
    begin
        value_clamped = (s1_value_reg > CLAMP_LIMIT) ? CLAMP_LIMIT : s1_value_reg;
        prod_div10    = 30'(value_clamped) * 30'd52429;
        prod_div100   = 30'(value_clamped) * 30'd5243;
        prod_div1000  = 28'(value_clamped) * 28'd16778;
        q1            = prod_div10[28:19];
        q2            = prod_div100[25:19];
        q3            = prod_div1000[27:24];
        digits[0]     = 4'(value_clamped - 14'(q1) * 14'd10);
        digits[1]     = 4'(q1 - 10'(q2) * 10'd10);
        digits[2]     = 4'(q2 - 7'(q3) * 7'd10);
        digits[3]     = q3;

        slot3     = 3'(s1_slot_reg);
        digit_pos = LAST_POS - slot3;
        // Positions above the thousands digit always read as zero.
        digit_sel = digit_pos[2] ? 4'd0 : digits[digit_pos[1:0]];

        if (s1_blink_reg)
        begin
            seg_next = {1'b0, sevseg_pkg::seg_pattern(4'd0)};
            en_next  = s1_phase_reg ? 4'b0000 : sevseg_pkg::EN_ALL_OFF;
        end
        else
        begin
            seg_next = {1'b0, sevseg_pkg::seg_pattern(digit_sel)};
            if (slot3 == {1'b0, dp_slot_reg})
            begin
                seg_next = seg_next | sevseg_pkg::DP_BIT;
            end
            en_next = sevseg_pkg::EN_ALL_OFF;
            if (!slot3[2])
            begin
                en_next[slot3[1:0]] = 1'b0;
            end
        end
    end

    // Output register.
    assign m_valid_next = out_ready ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            seg_reg <= seg_next;
            en_reg  <= en_next;
        end
    end

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_slot_reg <= LAST_SLOT)
        else $error("scan slot beyond the last digit");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while the output register is empty");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !m_valid_reg |=> m_valid_reg)
        else $error("item did not move into the empty output register");

    a_mode_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> last_mode_reg == $past(s_tuser))
        else $error("last mode not updated on an accepted item");
`endif

endmodule
